/* src/kh_pkg.sv */
// ----------------------------------------------------------------------------
// kh_pkg
// Types, codes and constants shared by the kettle heater mode controller.
// ----------------------------------------------------------------------------
package kh_pkg;

   // Clamp ceiling for temperature samples
   localparam int TEMP_CEILING = 150;

   // Reset value of the keep-warm setpoint
   localparam logic [6:0] SETPOINT_RESET = 7'd55;

   // Highest setpoint that fits the setpoint register
   localparam logic [6:0] SETPOINT_LIMIT = 7'd127;

   // Register indexes on the configuration port
   localparam logic [2:0] CFG_BOIL_THRESHOLD   = 3'd0;
   localparam logic [2:0] CFG_OVERHEAT_LIMIT   = 3'd1;
   localparam logic [2:0] CFG_DEFAULT_SETPOINT = 3'd2;
   localparam logic [2:0] CFG_BOIL_HOLD_TICKS  = 3'd3;
   localparam logic [2:0] CFG_UPPER_MARGIN     = 3'd4;
   localparam logic [2:0] CFG_LOWER_MARGIN     = 3'd5;
   localparam logic [2:0] CFG_SETPOINT_MIN     = 3'd6;
   localparam logic [2:0] CFG_SETPOINT_MAX     = 3'd7;

   // Input operation codes
   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_TEMP       = 3'd1,
      OP_BOIL_KEY   = 3'd2,
      OP_WARM_KEY   = 3'd3,
      OP_BOIL_CMD   = 3'd4,
      OP_WARM_CMD   = 3'd5,
      OP_SETPOINT   = 3'd6,
      OP_WATER_TYPE = 3'd7
   } op_type;

   // Heater modes, held one-hot
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_BOIL  = 4'b0010,
      MODE_BWARM = 4'b0100,
      MODE_HOLD  = 4'b1000
   } mode_type;

   // Reported mode codes
   localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CODE_BOIL  = 2'd1;
   localparam logic [1:0] MODE_CODE_BWARM = 2'd2;
   localparam logic [1:0] MODE_CODE_HOLD  = 2'd3;

   // Lamp bit positions
   localparam int LAMP_BOIL  = 0;
   localparam int LAMP_WARM  = 1;
   localparam int LAMP_READY = 2;

   // Configuration registers
   typedef struct packed {
      logic [7:0] boil_threshold;
      logic [7:0] overheat_limit;
      logic [6:0] default_setpoint;
      logic [5:0] boil_hold_ticks;
      logic [3:0] upper_margin;
      logic [3:0] lower_margin;
      logic [7:0] setpoint_min;
      logic [7:0] setpoint_max;
   } cfg_type;

   // Controller state
   typedef struct packed {
      mode_type   mode;
      logic [7:0] temp;
      logic [6:0] setpoint;
      logic       water_kind;
      logic       boil_flag;
      logic       warm_flag;
      logic       fault;
      logic [5:0] hold_count;
      logic       hold_running;
      logic       relay;
      logic [2:0] lamps;
   } state_type;

   // Encode the one-hot mode as its reported code
   function automatic logic [1:0] mode_code(mode_type m);
      logic [1:0] code;
      case (m)
         MODE_IDLE:  code = MODE_CODE_IDLE;
         MODE_BOIL:  code = MODE_CODE_BOIL;
         MODE_BWARM: code = MODE_CODE_BWARM;
         MODE_HOLD:  code = MODE_CODE_HOLD;
         default:    code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* src/kh_csr.sv */
// ----------------------------------------------------------------------------
// kh_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module kh_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_psel,
   input  logic           csr_penable,
   input  logic           csr_pwrite,
   input  logic [4:0]     csr_paddr,
   input  logic [31:0]    csr_pwdata,
   output logic [31:0]    csr_prdata,
   output logic           csr_pready,
   output kh_pkg::cfg_type cfg
);
   import kh_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode the write, truncating data to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CFG_BOIL_THRESHOLD:   cfg_in.boil_threshold   = csr_pwdata[7:0];
            CFG_OVERHEAT_LIMIT:   cfg_in.overheat_limit   = csr_pwdata[7:0];
            CFG_DEFAULT_SETPOINT: cfg_in.default_setpoint = csr_pwdata[6:0];
            CFG_BOIL_HOLD_TICKS:  cfg_in.boil_hold_ticks  = csr_pwdata[5:0];
            CFG_UPPER_MARGIN:     cfg_in.upper_margin     = csr_pwdata[3:0];
            CFG_LOWER_MARGIN:     cfg_in.lower_margin     = csr_pwdata[3:0];
            CFG_SETPOINT_MIN:     cfg_in.setpoint_min     = csr_pwdata[7:0];
            CFG_SETPOINT_MAX:     cfg_in.setpoint_max     = csr_pwdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, loading reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boil_threshold   <= 8'd97;
         cfg_ff.overheat_limit   <= 8'd105;
         cfg_ff.default_setpoint <= 7'd55;
         cfg_ff.boil_hold_ticks  <= 6'd5;
         cfg_ff.upper_margin     <= 4'd3;
         cfg_ff.lower_margin     <= 4'd5;
         cfg_ff.setpoint_min     <= 8'd45;
         cfg_ff.setpoint_max     <= 8'd90;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (index)
         CFG_BOIL_THRESHOLD:   csr_prdata = {24'd0, cfg_ff.boil_threshold};
         CFG_OVERHEAT_LIMIT:   csr_prdata = {24'd0, cfg_ff.overheat_limit};
         CFG_DEFAULT_SETPOINT: csr_prdata = {25'd0, cfg_ff.default_setpoint};
         CFG_BOIL_HOLD_TICKS:  csr_prdata = {26'd0, cfg_ff.boil_hold_ticks};
         CFG_UPPER_MARGIN:     csr_prdata = {28'd0, cfg_ff.upper_margin};
         CFG_LOWER_MARGIN:     csr_prdata = {28'd0, cfg_ff.lower_margin};
         CFG_SETPOINT_MIN:     csr_prdata = {24'd0, cfg_ff.setpoint_min};
         CFG_SETPOINT_MAX:     csr_prdata = {24'd0, cfg_ff.setpoint_max};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* src/kh_step.sv */
// ----------------------------------------------------------------------------
// kh_step
// Next-state logic: applies one operation to the controller state.
// ----------------------------------------------------------------------------
module kh_step (
   input  kh_pkg::cfg_type   cfg,
   input  kh_pkg::state_type cur,
   input  logic [2:0]        operation,
   input  logic signed [9:0] value,
   input  logic              switch_on,
   output kh_pkg::state_type nxt,
   output logic              alarm
);
   import kh_pkg::*;

   // Change mode, cancelling any hold count when leaving boil
   function automatic state_type set_mode(state_type s, mode_type m);
      state_type r;
      r = s;
      if (m != MODE_BOIL) begin
         r.hold_running = 1'b0;
         r.hold_count   = 6'd0;
      end
      r.mode = m;
      return r;
   endfunction

   logic signed [10:0] v_ext;
   logic signed [10:0] temp_s;
   logic signed [10:0] upper_s;
   logic signed [10:0] lower_s;
   logic               sp_ok;
   logic               def_ok;
   logic               reached;
   logic               overheat;
   logic [7:0]         clamped;

   assign v_ext    = {value[9], value};
   assign temp_s   = $signed({3'd0, cur.temp});
   assign upper_s  = $signed({4'd0, cur.setpoint}) - $signed({7'd0, cfg.upper_margin});
   assign lower_s  = $signed({4'd0, cur.setpoint}) - $signed({7'd0, cfg.lower_margin});
   assign reached  = cur.temp >= cfg.boil_threshold;
   assign overheat = cur.temp > cfg.overheat_limit;

   // Range check of a remote setpoint request
   assign sp_ok = (v_ext >= $signed({3'd0, cfg.setpoint_min}))
                & (v_ext <= $signed({3'd0, cfg.setpoint_max}))
                & (v_ext <= $signed({4'd0, SETPOINT_LIMIT}));

   // Same check for the default setpoint
   assign def_ok = ({1'b0, cfg.default_setpoint} >= cfg.setpoint_min)
                 & ({1'b0, cfg.default_setpoint} <= cfg.setpoint_max);

   // Clamp a temperature sample
   always_comb begin
      if (value[9]) begin
         clamped = 8'd0;
      end else if (v_ext > $signed(11'(TEMP_CEILING))) begin
         clamped = 8'(TEMP_CEILING);
      end else begin
         clamped = v_ext[7:0];
      end
   end

   always_comb begin
      nxt   = cur;
      alarm = 1'b0;
      case (op_type'(operation))
         OP_TICK: begin
            // Run the mode logic
            case (cur.mode)
               MODE_IDLE: begin
                  nxt.relay = 1'b0;
                  nxt.lamps = 3'd0;
               end
               MODE_BOIL: begin
                  if (cur.hold_running) begin
                     if (cur.hold_count <= 6'd1) begin
                        nxt           = set_mode(cur, MODE_IDLE);
                        nxt.relay     = 1'b0;
                        nxt.lamps     = 3'd0;
                        nxt.boil_flag = 1'b0;
                     end else begin
                        nxt.hold_count = cur.hold_count - 6'd1;
                        nxt.relay      = 1'b1;
                     end
                  end else if (reached) begin
                     nxt.hold_running = 1'b1;
                     nxt.hold_count   = cfg.boil_hold_ticks;
                     nxt.relay        = 1'b1;
                  end else begin
                     nxt.relay = 1'b1;
                     nxt.lamps = 3'd0;
                     nxt.lamps[LAMP_BOIL] = 1'b1;
                  end
               end
               MODE_BWARM: begin
                  if (reached) begin
                     nxt       = set_mode(cur, MODE_HOLD);
                     nxt.relay = 1'b0;
                  end else begin
                     nxt.relay = 1'b1;
                  end
                  nxt.lamps = 3'd0;
                  nxt.lamps[LAMP_WARM] = 1'b1;
               end
               default: begin
                  // Keep warm between the two margins
                  nxt.lamps = 3'd0;
                  if (temp_s > upper_s) begin
                     nxt.relay = 1'b0;
                     nxt.lamps[LAMP_WARM] = 1'b1;
                  end else if (temp_s < lower_s) begin
                     nxt.relay = 1'b1;
                     nxt.lamps[LAMP_WARM] = 1'b1;
                  end else begin
                     nxt.relay = 1'b0;
                     nxt.lamps[LAMP_READY] = 1'b1;
                  end
               end
            endcase
            // Force the relay off on over-temperature
            if (overheat) begin
               nxt.fault = 1'b1;
               nxt.relay = 1'b0;
               alarm     = 1'b1;
            end else begin
               nxt.fault = 1'b0;
            end
         end
         OP_TEMP: begin
            nxt.temp = clamped;
         end
         OP_BOIL_KEY: begin
            nxt.lamps[LAMP_BOIL] = 1'b0;
            if (cur.mode == MODE_BOIL) begin
               nxt           = set_mode(nxt, MODE_IDLE);
               nxt.boil_flag = 1'b0;
            end else begin
               nxt           = set_mode(nxt, MODE_BOIL);
               nxt.boil_flag = 1'b1;
            end
         end
         OP_WARM_KEY: begin
            nxt.lamps[LAMP_WARM] = 1'b0;
            if (cur.mode == MODE_BWARM) begin
               nxt           = set_mode(nxt, MODE_IDLE);
               nxt.warm_flag = 1'b0;
            end else begin
               nxt = set_mode(nxt, MODE_BWARM);
               if (def_ok) begin
                  nxt.setpoint = cfg.default_setpoint;
               end
               nxt.warm_flag = 1'b1;
            end
         end
         OP_BOIL_CMD: begin
            if (switch_on) begin
               nxt           = set_mode(cur, MODE_BOIL);
               nxt.boil_flag = 1'b1;
               nxt.warm_flag = 1'b0;
            end else begin
               nxt           = set_mode(cur, MODE_IDLE);
               nxt.boil_flag = 1'b0;
            end
         end
         OP_WARM_CMD: begin
            if (switch_on) begin
               nxt = set_mode(cur, cur.water_kind ? MODE_HOLD : MODE_BWARM);
               nxt.warm_flag = 1'b1;
               nxt.boil_flag = 1'b0;
            end else begin
               nxt           = set_mode(cur, MODE_IDLE);
               nxt.warm_flag = 1'b0;
            end
         end
         OP_SETPOINT: begin
            if (sp_ok) begin
               nxt.setpoint = v_ext[6:0];
            end
         end
         default: begin
            // Accept only tap or clear water, and swap warm modes to match
            if (value == 10'sd0 || value == 10'sd1) begin
               nxt.water_kind = value[0];
               if (cur.mode == MODE_BWARM && value[0]) begin
                  nxt = set_mode(nxt, MODE_HOLD);
               end else if (cur.mode == MODE_HOLD && !value[0]) begin
                  nxt = set_mode(nxt, MODE_BWARM);
               end
            end
         end
      endcase
   end

endmodule

/* src/kettle_heater_mode_controller.sv */
// ----------------------------------------------------------------------------
// kettle_heater_mode_controller
// Heater relay and lamp control for a kettle: idle, boil, boil-then-warm
// and hold-warm modes, driven by ticks, samples, keys and remote commands.
//
//   Channel  Direction  Carries
//   req_     in         tuser: operation; tdata: value, switch_on
//   rsp_     out        tdata: relay, mode, fault, lamps, alarm, status
//   csr_     in         APB-style writes and reads of eight registers
//
// Each item is taken into an input register, applied to the state by the
// next-state logic and its result loaded into the output register: one item
// a cycle while the output does not stall.
// The next-state logic in kh_step is combinational.
// Reset is synchronous and clears state and configuration to default values.
// A stalled result holds the output register; req_tready then drops once the
// input register is full.
// ----------------------------------------------------------------------------
module kettle_heater_mode_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // value[9:0], switch_on[10], zero[15:11]
   input  logic [2:0]  req_tuser,    // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heater_on[0], mode[2:1], fault[3], boil_lamp[4], warm_lamp[5],
   // ready_lamp[6], alarm_pulse[7], water_temp[15:8], warm_setpoint[22:16],
   // water_kind[23], boil_active[24], warm_active[25], zero[31:26]
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kh_pkg::*;

   cfg_type           cfg;
   state_type         state_ff;
   state_type         state_nxt;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [2:0]        op_ff;
   logic signed [9:0] value_ff;
   logic              on_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [31:0]       rsp_data_ff;
   logic [31:0]       rsp_data_in;
   logic              alarm;
   logic              advance;
   logic              fire;

   kh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kh_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .operation (op_ff),
      .value     (value_ff),
      .switch_on (on_ff),
      .nxt       (state_nxt),
      .alarm     (alarm)
   );

   // Handshake control
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Pack the result from the updated state
   assign rsp_data_in = {6'd0,
                         state_nxt.warm_flag,
                         state_nxt.boil_flag,
                         state_nxt.water_kind,
                         state_nxt.setpoint,
                         state_nxt.temp,
                         alarm,
                         state_nxt.lamps[LAMP_READY],
                         state_nxt.lamps[LAMP_WARM],
                         state_nxt.lamps[LAMP_BOIL],
                         state_nxt.fault,
                         mode_code(state_nxt.mode),
                         state_nxt.relay};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture an accepted item
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         value_ff <= $signed(req_tdata[9:0]);
         on_ff    <= req_tdata[10];
      end
   end

   // Commit the state and load the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= MODE_IDLE;
         state_ff.temp         <= 8'd0;
         state_ff.setpoint     <= SETPOINT_RESET;
         state_ff.water_kind   <= 1'b0;
         state_ff.boil_flag    <= 1'b0;
         state_ff.warm_flag    <= 1'b0;
         state_ff.fault        <= 1'b0;
         state_ff.hold_count   <= 6'd0;
         state_ff.hold_running <= 1'b0;
         state_ff.relay        <= 1'b0;
         state_ff.lamps        <= 3'd0;
      end else if (fire) begin
         state_ff <= state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A running hold count belongs to boil mode only
   a_hold_in_boil: assert property (@(posedge clock) disable iff (reset)
      state_ff.hold_running |-> state_ff.mode == MODE_BOIL)
      else $error("hold count running outside boil mode");

   // A latched fault keeps the relay off
   a_fault_relay: assert property (@(posedge clock) disable iff (reset)
      state_ff.fault |-> !state_ff.relay)
      else $error("relay on while fault is set");

   // A processed item always shows up as a result next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed item produced no result");

   // Input backpressure only when both stages are full and the output stalls
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");
`endif

endmodule
